FILE: rtl/core/plac_pkg.sv
// Shared types and constants for the position ledger.
`timescale 1ns / 1ps
`default_nettype none
package plac_pkg;
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [23:0] UNITS_LIMIT = 24'd8388607;
    localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [3:0]  slot;
        logic        is_sell;
        logic [15:0] quantity;
        logic [31:0] price;
        logic [15:0] multiplier;
    } fill_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_CLASS, ST_DPREP, ST_DIV, ST_MUL1, ST_MUL2A, ST_MUL2B,
        ST_MUL2C, ST_CHK, ST_ACC, ST_OUT
    } back_state_t;
endpackage
`default_nettype wire

FILE: rtl/core/position_ledger_avg_cost_pnl_top.sv
// Top level of the average-cost position ledger.
// One fill beat in, one result beat out. A queue takes beats while the back end
// works on one fill at a time. A query or opening fill goes straight to output;
// a closing fill uses a 48x24 multiply split over two stages, then clamp and
// accumulate; an adding fill waits on the bit-serial 64-bit divider for the
// weighted mean, unless the slot already sits at the units limit. The slot table
// resets flat through per-slot valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module position_ledger_avg_cost_pnl_top (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic [3:0] instrument_slot,
    input  wire logic is_sell,
    input  wire logic [15:0] quantity,
    input  wire logic [31:0] price,
    input  wire logic [15:0] multiplier,
    output logic out_valid,
    input  wire logic out_stall,
    output logic signed [23:0] units_now,
    output logic [31:0] average_entry,
    output logic signed [63:0] realized_total,
    output logic saturated
);
    import plac_pkg::*;
    fill_t in_fill, q_fill;
    logic q_valid, q_take;
    logic [23:0] u;
    logic [63:0] r;

    assign in_fill = '{slot: instrument_slot, is_sell: is_sell, quantity: quantity,
                       price: price, multiplier: multiplier};
    assign units_now = u;
    assign realized_total = r;

    plac_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_fill(in_fill), .q_valid(q_valid), .q_take(q_take), .q_fill(q_fill)
    );

    plac_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_fill(q_fill),
        .out_valid(out_valid), .out_stall(out_stall), .units_now(u),
        .average_entry(average_entry), .realized_total(r), .saturated(saturated)
    );
endmodule
`default_nettype wire

FILE: rtl/core/plac_front.sv
// Input front end: two-entry queue of accepted fill beats.
`timescale 1ns / 1ps
`default_nettype none
module plac_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire plac_pkg::fill_t in_fill,
    output logic q_valid,
    input  wire logic q_take,
    output plac_pkg::fill_t q_fill
);
    import plac_pkg::*;
    fill_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_take;
    assign q_fill = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_fill;
    end
endmodule
`default_nettype wire

FILE: rtl/core/plac_div.sv
// Restoring divider: 64-bit dividend by 24-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module plac_div (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [63:0] dividend,
    input  wire logic [23:0] divisor,
    output logic busy,
    output logic [63:0] quotient
);
    logic [63:0] q_reg;
    logic [24:0] r_reg;
    logic [23:0] d_reg;
    logic [6:0] cnt_reg;
    logic [24:0] trial;

    assign busy = (cnt_reg != 7'd0);
    assign quotient = q_reg;
    assign trial = {r_reg[23:0], q_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 7'd0;
        else if (start)
            cnt_reg <= 7'd64;
        else if (busy)
            cnt_reg <= cnt_reg - 7'd1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= 25'd0;
            d_reg <= divisor;
        end
        else if (busy)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/plac_back.sv
// Execution back end: slot table, averaging, realized profit and result register.
`timescale 1ns / 1ps
`default_nettype none
module plac_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    output logic q_take,
    input  wire plac_pkg::fill_t q_fill,
    output logic out_valid,
    input  wire logic out_stall,
    output logic [23:0] units_now,
    output logic [31:0] average_entry,
    output logic [63:0] realized_total,
    output logic saturated
);
    import plac_pkg::*;

    logic [23:0] units_mem [NUM_SLOTS];
    logic [31:0] avg_mem [NUM_SLOTS];
    logic [15:0] mult_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] vld_reg;

    back_state_t st_reg, st_next;
    fill_t f_reg;
    logic [SLOT_W-1:0] s_reg;
    logic [23:0] u_reg;
    logic [31:0] a_reg;
    logic [15:0] m_reg;
    logic [23:0] old_reg, eff_reg;
    logic long_reg, neg_reg, sat_reg, ovf_reg;
    logic [63:0] acc_reg, num_reg, mag_reg, m1_reg;
    logic [31:0] diff_reg;
    logic [63:0] pa_reg, pb_reg;
    logic ov_reg;
    logic [23:0] ou_reg;
    logic [31:0] oa_reg;
    logic [63:0] oacc_reg;
    logic osat_reg, ovalid_reg;

    logic div_start, div_busy;
    logic [63:0] div_q;
    logic [23:0] tot;

    assign q_take = (st_reg == ST_IDLE) && q_valid;
    assign tot = old_reg + eff_reg;
    assign out_valid = ovalid_reg;
    assign units_now = ou_reg;
    assign average_entry = oa_reg;
    assign realized_total = oacc_reg;
    assign saturated = osat_reg;

    plac_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(num_reg),
        .divisor(tot), .busy(div_busy), .quotient(div_q)
    );

    always_comb
    begin
        st_next = st_reg;
        div_start = 1'b0;
        unique case (st_reg)
            ST_IDLE:  if (q_valid) st_next = ST_READ;
            ST_READ:  st_next = ST_CLASS;
            ST_CLASS:
            begin
                if (f_reg.quantity == 16'd0 || u_reg == 24'd0)
                    st_next = ST_OUT;
                else if (long_reg != f_reg.is_sell)
                    st_next = ST_DPREP;
                else
                    st_next = ST_MUL1;
            end
            // eff_reg and num_reg are settled here
            ST_DPREP: st_next = (eff_reg != 24'd0) ? ST_DIV : ST_OUT;
            ST_DIV:   if (!div_busy) st_next = ST_OUT;
            ST_MUL1:  st_next = ST_MUL2A;
            ST_MUL2A: st_next = ST_MUL2B;
            ST_MUL2B: st_next = ST_MUL2C;
            ST_MUL2C: st_next = ST_CHK;
            ST_CHK:   st_next = ST_ACC;
            ST_ACC:   st_next = ST_OUT;
            ST_OUT:   if (!ovalid_reg || !out_stall) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
        if (st_reg == ST_DPREP && st_next == ST_DIV) div_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            vld_reg <= '0;
            acc_reg <= 64'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_OUT && (!ovalid_reg || !out_stall))
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            case (st_reg)
                ST_ACC:
                begin
                    if (mag_reg != 64'd0)
                    begin
                        if (!neg_reg)
                        begin
                            // clamp at the positive limit
                            if ($signed(acc_reg) > $signed(MAG_LIMIT - mag_reg))
                                acc_reg <= MAG_LIMIT;
                            else
                                acc_reg <= acc_reg + mag_reg;
                        end
                        else
                        begin
                            if ($signed(acc_reg) < $signed(mag_reg - MAG_LIMIT))
                                acc_reg <= -MAG_LIMIT;
                            else
                                acc_reg <= acc_reg - mag_reg;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (!ovalid_reg || !out_stall)
                        vld_reg[s_reg] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                f_reg <= q_fill;
                s_reg <= SLOT_W'(q_fill.slot % NUM_SLOTS);
            end
            ST_READ:
            begin
                sat_reg <= 1'b0;
                if (vld_reg[s_reg])
                begin
                    u_reg <= units_mem[s_reg];
                    a_reg <= avg_mem[s_reg];
                    m_reg <= mult_mem[s_reg];
                end
                else
                begin
                    u_reg <= 24'd0;
                    a_reg <= 32'd0;
                    m_reg <= 16'd0;
                end
                long_reg <= vld_reg[s_reg] && !units_mem[s_reg][23]
                    && (units_mem[s_reg] != 24'd0);
                old_reg <= !vld_reg[s_reg] ? 24'd0 :
                    (units_mem[s_reg][23] ? -units_mem[s_reg] : units_mem[s_reg]);
            end
            ST_CLASS:
            begin
                if (f_reg.quantity == 16'd0)
                    ;
                else if (u_reg == 24'd0)
                begin
                    u_reg <= f_reg.is_sell ? -{8'd0, f_reg.quantity}
                                           : {8'd0, f_reg.quantity};
                    a_reg <= f_reg.price;
                    m_reg <= f_reg.multiplier;
                end
                else if (long_reg != f_reg.is_sell)
                begin
                    // room left below the units limit
                    if ({8'd0, f_reg.quantity} > UNITS_LIMIT - old_reg)
                    begin
                        eff_reg <= UNITS_LIMIT - old_reg;
                        sat_reg <= 1'b1;
                    end
                    else
                        eff_reg <= {8'd0, f_reg.quantity};
                end
                else
                begin
                    eff_reg <= ({8'd0, f_reg.quantity} < old_reg)
                        ? {8'd0, f_reg.quantity} : old_reg;
                    diff_reg <= (f_reg.price >= a_reg) ? f_reg.price - a_reg
                                                       : a_reg - f_reg.price;
                    neg_reg <= long_reg ? (f_reg.price < a_reg) : (f_reg.price > a_reg);
                end
            end
            default: ;
        endcase
        // eff_reg is registered in CLASS; the numerator is built in CLASS too, from the same clamp
        if (st_reg == ST_CLASS)
            num_reg <= 64'(a_reg) * 64'(old_reg)
                + 64'(f_reg.price) * 64'(({8'd0, f_reg.quantity} > UNITS_LIMIT - old_reg)
                    ? UNITS_LIMIT - old_reg : {8'd0, f_reg.quantity});
        case (st_reg)
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    a_reg <= div_q[31:0];
                    u_reg <= long_reg ? tot : -tot;
                end
            end
            ST_MUL1:  m1_reg <= 64'(diff_reg) * 64'(m_reg);
            ST_MUL2A:
            begin
                pa_reg <= 64'(m1_reg[31:0]) * 64'(eff_reg);
                pb_reg <= 64'(m1_reg[47:32]) * 64'(eff_reg);
            end
            ST_MUL2B:
            begin
                ov_reg <= (pb_reg[63:32] != 32'd0);
                mag_reg <= pa_reg + {pb_reg[31:0], 32'd0};
                ovf_reg <= (({1'b0, pa_reg} + {1'b0, pb_reg[31:0], 32'd0}) >> 64) != 65'd0;
            end
            ST_MUL2C:
            begin
                if (ov_reg || ovf_reg || mag_reg > MAG_LIMIT)
                begin
                    mag_reg <= MAG_LIMIT;
                    sat_reg <= 1'b1;
                end
            end
            ST_CHK:
            begin
                if (mag_reg != 64'd0)
                begin
                    if (!neg_reg && $signed(acc_reg) > $signed(MAG_LIMIT - mag_reg))
                        sat_reg <= 1'b1;
                    if (neg_reg && $signed(acc_reg) < $signed(mag_reg - MAG_LIMIT))
                        sat_reg <= 1'b1;
                end
                if ({8'd0, f_reg.quantity} == old_reg)
                begin
                    u_reg <= 24'd0;
                    a_reg <= 32'd0;
                    m_reg <= 16'd0;
                end
                else if ({8'd0, f_reg.quantity} > old_reg)
                begin
                    u_reg <= long_reg ? old_reg - {8'd0, f_reg.quantity}
                                      : {8'd0, f_reg.quantity} - old_reg;
                    a_reg <= f_reg.price;
                    m_reg <= f_reg.multiplier;
                end
                else
                    u_reg <= long_reg ? old_reg - {8'd0, f_reg.quantity}
                                      : {8'd0, f_reg.quantity} - old_reg;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    units_mem[s_reg] <= u_reg;
                    avg_mem[s_reg] <= a_reg;
                    mult_mem[s_reg] <= m_reg;
                    ou_reg <= u_reg;
                    oa_reg <= a_reg;
                    oacc_reg <= acc_reg;
                    osat_reg <= sat_reg;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
